### design/b32d_pkg.sv
// ----------------------------------------------------------------------------
// b32d_pkg: shared types and constants of the dashed base32 encoder
// Holds the job record that passes from the front part to the back part,
// the character codes and the alphabet and padding lookups.
// ----------------------------------------------------------------------------
package b32d_pkg;

  localparam int unsigned SymW    = 5;
  localparam int unsigned CharW   = 7;
  localparam int unsigned NumSlot = 3;

  localparam logic [CharW-1:0] DashChar = 7'h2D;
  localparam logic [CharW-1:0] PadChar  = 7'h3D;

  typedef logic [SymW-1:0]  sym_t;
  typedef logic [CharW-1:0] char_t;

  // One accepted byte after classification: symbols in order, then padding.
  typedef struct packed {
    logic [NumSlot-1:0][SymW-1:0] sym;
    logic [1:0]                   n_sym;
    logic [2:0]                   n_pad;
    logic                         last;
  } job_t;

  function automatic char_t alphabet(input sym_t v);
    char_t c;
    if (v < 5'd26) begin
      c = 7'h41 + {2'b00, v};
    end else begin
      c = 7'h32 + {2'b00, v - 5'd26};
    end
    return c;
  endfunction

  // '=' count after the final byte, by bytes in its five-byte group.
  function automatic logic [2:0] pad_count(input logic [2:0] bytes_in_group);
    logic [2:0] p;
    unique case (bytes_in_group)
      3'd1:    p = 3'd6;
      3'd2:    p = 3'd4;
      3'd3:    p = 3'd3;
      3'd4:    p = 3'd1;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

### design/b32d_front.sv
// ----------------------------------------------------------------------------
// b32d_front: byte intake and symbol slicing
// Accepts one byte a cycle while q_full is low, splits it with the carry into
// base32 symbols, works out flush and padding on the last byte, pushes a job.
// ----------------------------------------------------------------------------
module b32d_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             in_ready,
  input  logic             q_full,
  output logic             q_push,
  output b32d_pkg::job_t   q_job
);

  logic [3:0]  carry_bits_r, carry_bits_nxt;
  logic [2:0]  carry_count_r, carry_count_nxt;
  logic [2:0]  group_idx_r, group_idx_nxt;

  logic [2:0]  cc;
  logic [3:0]  nbits;
  logic        two;
  logic [3:0]  rem;
  logic [11:0] acc;
  logic [11:0] low;
  logic [11:0] sh0, sh1, flush_w;
  logic [2:0]  g_mod;
  logic [2:0]  bytes_in_group;
  logic        do_flush;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    cc       = (carry_count_r > 3'd4) ? 3'd4 : carry_count_r;
    nbits    = {1'b0, cc} + 4'd8;
    acc      = {carry_bits_r, in_byte};
    two      = (nbits >= 4'd10);
    rem      = two ? (nbits - 4'd10) : (nbits - 4'd5);
    sh0      = acc >> (nbits - 4'd5);
    sh1      = acc >> (nbits - 4'd10);
    low      = acc & ((12'd1 << rem) - 12'd1);
    flush_w  = low << (4'd5 - rem);
    do_flush = in_last && (rem != 4'd0);
    g_mod    = (group_idx_r >= 3'd5) ? (group_idx_r - 3'd5) : group_idx_r;
    bytes_in_group = g_mod + 3'd1;

    q_job.sym[0] = sh0[4:0];
    q_job.sym[1] = two ? sh1[4:0] : flush_w[4:0];
    q_job.sym[2] = flush_w[4:0];
    q_job.n_sym  = (two ? 2'd2 : 2'd1) + {1'b0, do_flush};
    q_job.n_pad  = in_last ? b32d_pkg::pad_count(bytes_in_group) : 3'd0;
    q_job.last   = in_last;

    carry_bits_nxt  = carry_bits_r;
    carry_count_nxt = carry_count_r;
    group_idx_nxt   = group_idx_r;
    if (q_push) begin
      if (in_last) begin
        carry_bits_nxt  = 4'd0;
        carry_count_nxt = 3'd0;
        group_idx_nxt   = 3'd0;
      end else begin
        carry_bits_nxt  = low[3:0];
        carry_count_nxt = rem[2:0];
        group_idx_nxt   = (bytes_in_group == 3'd5) ? 3'd0 : bytes_in_group;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_bits_r  <= 4'd0;
      carry_count_r <= 3'd0;
      group_idx_r   <= 3'd0;
    end else begin
      carry_bits_r  <= carry_bits_nxt;
      carry_count_r <= carry_count_nxt;
      group_idx_r   <= group_idx_nxt;
    end
  end

endmodule

### design/b32d_fifo.sv
// ----------------------------------------------------------------------------
// b32d_fifo: job queue
// Short first-in first-out store of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module b32d_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b32d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output b32d_pkg::job_t head_job,
  output logic           empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  b32d_pkg::job_t  mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == DepthCnt);
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### design/b32d_back.sv
// ----------------------------------------------------------------------------
// b32d_back: character sequencer
// Expands the head job into characters, one a cycle when out_ready allows,
// puts a dash before each later group, and holds the output register.
// ----------------------------------------------------------------------------
module b32d_back #(
  parameter int unsigned DASH_GROUP = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  b32d_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char,
  output logic           out_run_last,
  output logic           out_text_end
);

  localparam int unsigned CntW = $clog2(DASH_GROUP + 1);
  localparam logic [CntW-1:0] GroupLen = CntW'(DASH_GROUP);

  logic [3:0]       idx_r, idx_nxt;
  logic [CntW-1:0]  grp_cnt_r, grp_cnt_nxt;
  logic             sent_r, sent_nxt;
  logic             valid_r, valid_nxt;
  logic [6:0]       char_r, char_nxt;
  logic             run_last_r, run_last_nxt;
  logic             text_end_r, text_end_nxt;

  logic             load, go, need_dash, final_char;
  logic [3:0]       total;
  b32d_pkg::char_t  cur_char;

  assign out_valid    = valid_r;
  assign out_char     = char_r;
  assign out_run_last = run_last_r;
  assign out_text_end = text_end_r;

  always_comb begin
    load       = !valid_r || out_ready;
    go         = load && !q_empty;
    need_dash  = sent_r && (grp_cnt_r >= GroupLen);
    total      = {2'b00, q_job.n_sym} + {1'b0, q_job.n_pad};
    final_char = (idx_r == total - 4'd1);
    cur_char   = (idx_r < {2'b00, q_job.n_sym}) ?
                 b32d_pkg::alphabet(q_job.sym[idx_r[1:0]]) : b32d_pkg::PadChar;
    q_pop      = go && !need_dash && final_char;

    idx_nxt      = idx_r;
    grp_cnt_nxt  = grp_cnt_r;
    sent_nxt     = sent_r;
    valid_nxt    = load ? 1'b0 : valid_r;
    char_nxt     = char_r;
    run_last_nxt = run_last_r;
    text_end_nxt = text_end_r;

    if (go) begin
      valid_nxt = 1'b1;
      if (need_dash) begin
        char_nxt     = b32d_pkg::DashChar;
        run_last_nxt = 1'b0;
        text_end_nxt = 1'b0;
        grp_cnt_nxt  = '0;
      end else begin
        char_nxt     = cur_char;
        run_last_nxt = final_char;
        text_end_nxt = final_char && q_job.last;
        grp_cnt_nxt  = grp_cnt_r + 1'b1;
        sent_nxt     = 1'b1;
        idx_nxt      = idx_r + 4'd1;
        if (final_char) begin
          idx_nxt = 4'd0;
          if (q_job.last) begin
            grp_cnt_nxt = '0;
            sent_nxt    = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= 4'd0;
      grp_cnt_r <= '0;
      sent_r    <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      grp_cnt_r <= grp_cnt_nxt;
      sent_r    <= sent_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    run_last_r <= run_last_nxt;
    text_end_r <= text_end_nxt;
  end

endmodule

### design/base32_encoder_dashed.sv
// Base32 text encoder with dash grouping. Send a message as raw bytes, one
// per transaction on the in_ stream, with in_tlast on the final byte (a
// message has at least one byte). The out_ stream gives one ASCII character
// per transaction: symbols A-Z and 2-7, '=' padding to a multiple of eight
// characters, and a '-' between each run of DASH_GROUP characters and
// the next. out_tlast marks the last character caused by an input byte,
// out_tuser the final character of the message. The output side moves one
// character per cycle from its output register while out_tready is high
// and the job queue holds a job. The intake takes a byte every cycle until
// the job queue of QUEUE_DEPTH entries between slicer and character
// sequencer fills.
// ----------------------------------------------------------------------------
// base32_encoder_dashed: top level
// Joins the byte slicer, the job queue and the character sequencer.
// ----------------------------------------------------------------------------
module base32_encoder_dashed #(
  parameter int unsigned DASH_GROUP  = 5,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] text_char, [7] zero
  output logic       out_tlast,  // last_of_run
  output logic       out_tuser   // end_of_text
);

  b32d_pkg::job_t push_job, head_job;
  logic           q_push, q_full, q_pop, q_empty;
  logic [6:0]     text_char;

  assign out_tdata = {1'b0, text_char};

  b32d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  b32d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  b32d_back #(
    .DASH_GROUP (DASH_GROUP)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_job        (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_char     (text_char),
    .out_run_last (out_tlast),
    .out_text_end (out_tuser)
  );

endmodule
